// ===== sv/ftl_pkg.sv =====
`default_nettype none

package ftl_pkg;

    localparam int TABLE_DEPTH_DEF = 4096;

    localparam int ACTION_W   = 2;
    localparam int FRAMENUM_W = 32;
    localparam int TIME_W     = 64;
    localparam int STATUS_W   = 3;
    localparam int FRAME_W    = 12;
    localparam int COUNT_W    = 13;

    typedef logic [ACTION_W-1:0] t_action;
    typedef logic [STATUS_W-1:0] t_status;

    localparam t_action ACT_CLEAR  = 2'd0;
    localparam t_action ACT_APPEND = 2'd1;
    localparam t_action ACT_START  = 2'd2;
    localparam t_action ACT_AT     = 2'd3;

    localparam t_status ST_OK       = 3'd0;
    localparam t_status ST_BAD_APND = 3'd1;
    localparam t_status ST_BAD_ID   = 3'd2;
    localparam t_status ST_NEG_TIME = 3'd3;
    localparam t_status ST_EMPTY    = 3'd4;

    typedef struct packed {
        t_status             status;
        logic [FRAME_W-1:0]  found_frame;
        logic [TIME_W-1:0]   found_time;
        logic [COUNT_W-1:0]  entry_count;
    } t_result;

endpackage

`default_nettype wire

// ===== sv/ftl_mem.sv =====
`default_nettype none

module ftl_mem
    import ftl_pkg::*;
#(
    parameter int DEPTH = TABLE_DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_wr_en,
    input  wire logic [AW-1:0]     i_wr_addr,
    input  wire logic [TIME_W-1:0] i_wr_data,
    input  wire logic              i_rd_en,
    input  wire logic [AW-1:0]     i_rd_addr,
    output logic      [TIME_W-1:0] o_rd_data
);

    logic [TIME_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== sv/frame_timeline_lookup_core.sv =====
// Frame timeline lookup core.
// Input channel: i_valid / o_stall carry one word of i_action, i_frame_number
// and i_time_value. A word is taken at a clock edge with i_valid high and
// o_stall low. Output channel: o_valid / i_stall carry one result word per
// input word: o_status, o_found_frame, o_found_time and o_entry_count.
// Clear, append and every error answer pass from acceptance straight to
// S_DONE and from there to the output register. A start-time query reads
// the table once in S_WAIT first. A search alternates S_PROBE and S_CMP,
// one table read per probe, at most ceil(log2(entries+1)) probes.
// The block works on one word at a time; o_stall is high while a word is
// being processed, and the next word is taken only after the previous
// result has moved to the output register.
// A finished result waits in the output register, so the next word is
// accepted while the receiver holds i_stall high; a second finished result
// waits inside the core until the output register frees.
// A synchronous reset (i_rst_n low) empties the table and drops o_valid;
// table contents are not cleared, only entries below the count are read.
`default_nettype none

module frame_timeline_lookup_core
    import ftl_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_stall,
    input  wire logic [ACTION_W-1:0]          i_action,
    input  wire logic signed [FRAMENUM_W-1:0] i_frame_number,
    input  wire logic signed [TIME_W-1:0]     i_time_value,
    output logic                              o_valid,
    input  wire logic                         i_stall,
    output logic [STATUS_W-1:0]               o_status,
    output logic [FRAME_W-1:0]                o_found_frame,
    output logic signed [TIME_W-1:0]          o_found_time,
    output logic [COUNT_W-1:0]                o_entry_count
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] FULL = CW'(TABLE_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_WAIT,
        S_PROBE,
        S_CMP,
        S_DONE
    } t_state;

    t_state            r_state, n_state;
    logic [CW-1:0]     r_count, n_count;
    logic [TIME_W-1:0] r_last,  n_last;
    logic [TIME_W-1:0] r_time,  n_time;
    logic [CW-1:0]     r_lo,    n_lo;
    logic [CW-1:0]     r_hi,    n_hi;
    logic [CW-1:0]     r_mid,   n_mid;
    t_result           r_res,   n_res;
    t_result           r_out,   n_out;
    logic              r_out_valid, n_out_valid;

    logic              mem_we;
    logic              mem_re;
    logic [AW-1:0]     mem_raddr;
    logic [TIME_W-1:0] mem_rdata;
    logic [CW:0]       sum;
    logic [CW-1:0]     mid;
    logic              append_ok;
    logic              frame_bad;

    ftl_mem #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (mem_we),
        .i_wr_addr (r_count[AW-1:0]),
        .i_wr_data (i_time_value),
        .i_rd_en   (mem_re),
        .i_rd_addr (mem_raddr),
        .o_rd_data (mem_rdata)
    );

    assign sum = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid = sum[CW:1];

    always_comb begin
        if (r_count == FULL) begin
            append_ok = 1'b0;
        end else if (r_count == '0) begin
            append_ok = (i_time_value == '0);
        end else begin
            append_ok = (i_time_value > $signed(r_last));
        end
    end

    assign frame_bad = i_frame_number[FRAMENUM_W-1]
                    || ($unsigned(i_frame_number) >= FRAMENUM_W'(r_count));

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_last      = r_last;
        n_time      = r_time;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_mid       = r_mid;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_stall;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        mem_raddr   = r_mid[AW-1:0];

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_res   = '0;
                    n_state = S_DONE;
                    case (i_action)
                        ACT_CLEAR: begin
                            n_count = '0;
                            n_last  = '0;
                        end
                        ACT_APPEND: begin
                            if (append_ok) begin
                                mem_we  = 1'b1;
                                n_count = r_count + 1'b1;
                                n_last  = i_time_value;
                            end else begin
                                n_res.status = ST_BAD_APND;
                            end
                        end
                        ACT_START: begin
                            if (r_count == '0) begin
                                n_res.status = ST_EMPTY;
                            end else if (frame_bad) begin
                                n_res.status = ST_BAD_ID;
                            end else begin
                                mem_re    = 1'b1;
                                mem_raddr = i_frame_number[AW-1:0];
                                n_state   = S_WAIT;
                            end
                        end
                        default: begin
                            if (r_count == '0) begin
                                n_res.status = ST_EMPTY;
                            end else if (i_time_value[TIME_W-1]) begin
                                n_res.status = ST_NEG_TIME;
                            end else begin
                                n_time  = i_time_value;
                                n_lo    = '0;
                                n_hi    = r_count;
                                n_state = S_PROBE;
                            end
                        end
                    endcase
                end
            end
            S_WAIT: begin
                n_res.found_time = mem_rdata;
                n_state          = S_DONE;
            end
            S_PROBE: begin
                if (r_lo < r_hi) begin
                    mem_re    = 1'b1;
                    mem_raddr = mid[AW-1:0];
                    n_mid     = mid;
                    n_state   = S_CMP;
                end else begin
                    // The last entry at or below the query is one below lo.
                    if (r_lo != '0) begin
                        n_res.found_frame = FRAME_W'(r_lo - 1'b1);
                    end
                    n_state = S_DONE;
                end
            end
            S_CMP: begin
                if ($signed(mem_rdata) <= $signed(r_time)) begin
                    n_lo = r_mid + 1'b1;
                end else begin
                    n_hi = r_mid;
                end
                n_state = S_PROBE;
            end
            S_DONE: begin
                if (!r_out_valid || !i_stall) begin
                    n_out             = r_res;
                    n_out.entry_count = COUNT_W'(r_count);
                    n_out_valid       = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_last      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_last      <= n_last;
            r_out_valid <= n_out_valid;
        end
        r_time <= n_time;
        r_lo   <= n_lo;
        r_hi   <= n_hi;
        r_mid  <= n_mid;
        r_res  <= n_res;
        r_out  <= n_out;
    end

    assign o_stall       = (r_state != S_IDLE);
    assign o_valid       = r_out_valid;
    assign o_status      = r_out.status;
    assign o_found_frame = r_out.found_frame;
    assign o_found_time  = r_out.found_time;
    assign o_entry_count = r_out.entry_count;

endmodule

`default_nettype wire
